// ===== sv/csst_pkg.sv =====
// Shared constants, types and the parameter table of the cubic segment tessellator.
package csst_pkg;

	localparam int SEGMENT_STEPS = 32;
	localparam int COORD_WIDTH   = 16;

	localparam int STEP_W  = $clog2(SEGMENT_STEPS + 1);
	localparam int FRAC_W  = 16;
	localparam int T_W     = FRAC_W + 1;
	localparam int OP_W    = 2;
	localparam int CMB_W   = COORD_WIDTH + 4;
	localparam int SIXTH_W = 15;
	localparam int PRD_W   = CMB_W + SIXTH_W;
	localparam int COEF_W  = COORD_WIDTH + 8;
	localparam int V_W     = COEF_W + 2;
	localparam int HP_W    = V_W + T_W + 1;

	localparam logic signed [SIXTH_W-1:0] SIXTH = SIXTH_W'(10923);

	localparam logic [OP_W-1:0] OP_HERMITE = 2'd0;
	localparam logic [OP_W-1:0] OP_BEZIER  = 2'd1;
	localparam logic [OP_W-1:0] OP_BSPLINE = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [COEF_W-1:0]      coef_t;
	typedef logic signed [V_W-1:0]         val_t;
	typedef logic [T_W-1:0]                tparam_t;
	typedef logic [STEP_W-1:0]             step_t;

	typedef struct packed {
		coef_t a3;
		coef_t a2;
		coef_t a1;
		coef_t a0;
	} coefs_t;

	typedef struct packed {
		logic vld;
		logic last;
	} ptag_t;

	typedef tparam_t t_lut_t [SEGMENT_STEPS+1];

	// t = round(i / SEGMENT_STEPS) in Q1.16, built at elaboration
	function automatic t_lut_t gen_t_lut();
		t_lut_t lut;
		for (int i = 0; i <= SEGMENT_STEPS; i++) begin
			lut[i] = T_W'(((i << FRAC_W) + SEGMENT_STEPS / 2) / SEGMENT_STEPS);
		end
		return lut;
	endfunction

	localparam t_lut_t T_LUT = gen_t_lut();

endpackage

// ===== sv/csst_if.sv =====
// Segment and point channel interfaces.
interface csst_seg_if;
	import csst_pkg::*;
	logic            valid;
	logic            ready;
	logic [OP_W-1:0] op;
	coord_t          c0_x;
	coord_t          c0_y;
	coord_t          c1_x;
	coord_t          c1_y;
	coord_t          c2_x;
	coord_t          c2_y;
	coord_t          c3_x;
	coord_t          c3_y;
	modport source (output valid, op, c0_x, c0_y, c1_x, c1_y, c2_x, c2_y, c3_x, c3_y,
		input ready);
	modport sink (input valid, op, c0_x, c0_y, c1_x, c1_y, c2_x, c2_y, c3_x, c3_y,
		output ready);
endinterface

interface csst_pt_if;
	import csst_pkg::*;
	logic   valid;
	logic   ready;
	coord_t px;
	coord_t py;
	logic   last;
	modport source (output valid, px, py, last, input ready);
	modport sink (input valid, px, py, last, output ready);
endinterface

// ===== sv/cubic_spline_segment_tessellator.sv =====
// Cubic segment tessellator top level: input stages, step counter, lanes, merge.
// Path: a taken word passes input stages s1 and s2, the generator registers, the Horner
// stages and the output word register. Throughput: one point per cycle while pts is not stalled,
// set by the step counter that issues one t value per advancing cycle into the Horner lanes.
// A selector of 3 is taken and dropped, giving no points.
// Reset (arst_n low, asynchronous) clears valids, busy flag and step counter.
module cubic_spline_segment_tessellator (
	input  logic       clk,
	input  logic       arst_n,
	csst_seg_if.sink   seg,
	csst_pt_if.source  pts
);
	import csst_pkg::*;

	// input stage valids: s1 holds control values, s2 holds the coefficient words
	logic    seg_v_s1, seg_v_s2;
	logic    s1_ready, s2_ready;
	logic    en_s1;
	logic    adv;

	// point generator
	logic    busy_q;
	step_t   step_q;
	logic    last_step;
	logic    gen_load;
	coefs_t  cx, cy;
	coefs_t  coeff_x_q, coeff_y_q;
	ptag_t   tag_s0, tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	tparam_t t_s0;
	val_t    vx, vy;

	assign last_step = (step_q == STEP_W'(SEGMENT_STEPS));

	// a waiting segment takes over the generator as the previous one issues its last point
	assign gen_load = adv && seg_v_s2 && (!busy_q || last_step);
	assign s2_ready = !seg_v_s2 || gen_load;
	assign s1_ready = !seg_v_s1 || s2_ready;
	assign en_s1    = seg.valid && s1_ready;

	assign seg.ready = s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_v_s1 <= 1'b0;
			seg_v_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				seg_v_s1 <= seg.valid && (seg.op != OP_NONE);
			end
			if (s2_ready) begin
				seg_v_s2 <= seg_v_s1;
			end
		end
	end

	csst_coef u_coef_x (
		.clk   (clk),
		.en_s1 (en_s1),
		.en_s2 (s2_ready),
		.op    (seg.op),
		.p0    (seg.c0_x),
		.p1    (seg.c1_x),
		.p2    (seg.c2_x),
		.p3    (seg.c3_x),
		.coefs (cx)
	);

	csst_coef u_coef_y (
		.clk   (clk),
		.en_s1 (en_s1),
		.en_s2 (s2_ready),
		.op    (seg.op),
		.p0    (seg.c0_y),
		.p1    (seg.c1_y),
		.p2    (seg.c2_y),
		.p3    (seg.c3_y),
		.coefs (cy)
	);

	// step counter: issues one point per advancing cycle while busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (adv) begin
			if (gen_load) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (last_step) begin
					busy_q <= 1'b0;
					step_q <= '0;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gen_load) begin
			coeff_x_q <= cx;
			coeff_y_q <= cy;
		end
	end

	assign tag_s0.vld  = busy_q;
	assign tag_s0.last = last_step;
	assign t_s0        = T_LUT[step_q];

	// point tags ride alongside the six Horner stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
		end else if (adv) begin
			tag_s1 <= tag_s0;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
		end
	end

	csst_horner u_horner_x (
		.clk   (clk),
		.adv   (adv),
		.coefs (coeff_x_q),
		.t     (t_s0),
		.v     (vx)
	);

	csst_horner u_horner_y (
		.clk   (clk),
		.adv   (adv),
		.coefs (coeff_y_q),
		.t     (t_s0),
		.v     (vy)
	);

	// merge drives adv: the generator and lanes stall only while a point word waits
	csst_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.tag    (tag_s6),
		.vx     (vx),
		.vy     (vy),
		.adv    (adv),
		.pts    (pts)
	);

endmodule

// ===== sv/csst_coef.sv =====
// One axis lane: basis matrix product, two stages, B-spline sixth scaling.
module csst_coef (
	input  logic                      clk,
	input  logic                      en_s1,
	input  logic                      en_s2,
	input  logic [csst_pkg::OP_W-1:0] op,
	input  csst_pkg::coord_t          p0,
	input  csst_pkg::coord_t          p1,
	input  csst_pkg::coord_t          p2,
	input  csst_pkg::coord_t          p3,
	output csst_pkg::coefs_t          coefs
);
	import csst_pkg::*;

	localparam logic signed [CMB_W-1:0] K2 = CMB_W'(2);
	localparam logic signed [CMB_W-1:0] K3 = CMB_W'(3);
	localparam logic signed [CMB_W-1:0] K4 = CMB_W'(4);
	localparam logic signed [CMB_W-1:0] K6 = CMB_W'(6);
	localparam logic signed [PRD_W-1:0] RND = PRD_W'(1) <<< (FRAC_W - 1);

	logic [OP_W-1:0]          op_s1, op_s2;
	coord_t                   p0_s1, p1_s1, p2_s1, p3_s1;
	logic signed [CMB_W-1:0]  e0, e1, e2, e3;
	logic signed [CMB_W-1:0]  k [4];
	logic signed [PRD_W-1:0]  m [4];
	logic signed [CMB_W-1:0]  k_s2 [4];
	logic signed [PRD_W-1:0]  m_s2 [4];
	coef_t                    c [4];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1 <= op;
			p0_s1 <= p0;
			p1_s1 <= p1;
			p2_s1 <= p2;
			p3_s1 <= p3;
		end
	end

	assign e0 = CMB_W'(p0_s1);
	assign e1 = CMB_W'(p1_s1);
	assign e2 = CMB_W'(p2_s1);
	assign e3 = CMB_W'(p3_s1);

	always_comb begin
		case (op_s1)
			OP_HERMITE: begin
				k[0] = e0;
				k[1] = e2;
				k[2] = K3 * (e1 - e0) - K2 * e2 - e3;
				k[3] = K2 * (e0 - e1) + e2 + e3;
			end
			OP_BEZIER: begin
				k[0] = e0;
				k[1] = K3 * (e1 - e0);
				k[2] = K3 * (e0 + e2) - K6 * e1;
				k[3] = K3 * (e1 - e2) + e3 - e0;
			end
			default: begin
				// B-spline; the unused code also lands here, but its word carries no valid and is never loaded
				k[0] = e0 + K4 * e1 + e2;
				k[1] = K3 * (e2 - e0);
				k[2] = K3 * (e0 + e2) - K6 * e1;
				k[3] = K3 * (e1 - e2) + e3 - e0;
			end
		endcase
		for (int j = 0; j < 4; j++) begin
			m[j] = PRD_W'(k[j]) * PRD_W'(SIXTH);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			op_s2 <= op_s1;
			for (int j = 0; j < 4; j++) begin
				k_s2[j] <= k[j];
				m_s2[j] <= m[j];
			end
		end
	end

	// sixths rounded half up at 16 fraction bits
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			if (op_s2 == OP_BSPLINE) begin
				c[j] = COEF_W'((m_s2[j] + RND) >>> FRAC_W);
			end else begin
				c[j] = COEF_W'(k_s2[j]);
			end
		end
	end

	assign coefs.a0 = c[0];
	assign coefs.a1 = c[1];
	assign coefs.a2 = c[2];
	assign coefs.a3 = c[3];

endmodule

// ===== sv/csst_horner.sv =====
// One axis lane: three Horner steps, multiply and round-add in separate stages.
module csst_horner (
	input  logic              clk,
	input  logic              adv,
	input  csst_pkg::coefs_t  coefs,
	input  csst_pkg::tparam_t t,
	output csst_pkg::val_t    v
);
	import csst_pkg::*;

	localparam logic signed [HP_W-1:0] RND = HP_W'(1) <<< (FRAC_W - 1);

	function automatic val_t rnd16(logic signed [HP_W-1:0] p);
		logic signed [HP_W-1:0] s;
		s = (p + RND) >>> FRAC_W;
		return V_W'(s);
	endfunction

	function automatic logic signed [HP_W-1:0] mul_t(val_t a, tparam_t tt);
		logic signed [T_W:0] ts;
		ts = $signed({1'b0, tt});
		return HP_W'(a) * HP_W'(ts);
	endfunction

	logic signed [HP_W-1:0] p_s1, p_s3, p_s5;
	val_t                   v_s2, v_s4, v_s6;
	tparam_t                t_s1, t_s2, t_s3, t_s4;
	coef_t                  a0_s1, a0_s2, a0_s3, a0_s4, a0_s5;
	coef_t                  a1_s1, a1_s2, a1_s3;
	coef_t                  a2_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1  <= mul_t(V_W'($signed(coefs.a3)), t);
			t_s1  <= t;
			a0_s1 <= coefs.a0;
			a1_s1 <= coefs.a1;
			a2_s1 <= coefs.a2;

			v_s2  <= V_W'($signed(a2_s1)) + rnd16(p_s1);
			t_s2  <= t_s1;
			a0_s2 <= a0_s1;
			a1_s2 <= a1_s1;

			p_s3  <= mul_t(v_s2, t_s2);
			t_s3  <= t_s2;
			a0_s3 <= a0_s2;
			a1_s3 <= a1_s2;

			v_s4  <= V_W'($signed(a1_s3)) + rnd16(p_s3);
			t_s4  <= t_s3;
			a0_s4 <= a0_s3;

			p_s5  <= mul_t(v_s4, t_s4);
			a0_s5 <= a0_s4;

			v_s6  <= V_W'($signed(a0_s5)) + rnd16(p_s5);
		end
	end

	assign v = v_s6;

endmodule

// ===== sv/csst_merge.sv =====
// Joins the two axis lanes: saturation and the output word register.
module csst_merge (
	input  logic             clk,
	input  logic             arst_n,
	input  csst_pkg::ptag_t  tag,
	input  csst_pkg::val_t   vx,
	input  csst_pkg::val_t   vy,
	output logic             adv,
	csst_pt_if.source        pts
);
	import csst_pkg::*;

	localparam val_t V_HI = V_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
	localparam val_t V_LO = V_W'(-(64'sd1 <<< (COORD_WIDTH - 1)));

	function automatic coord_t sat(val_t a);
		val_t r;
		r = a;
		if (a > V_HI) r = V_HI;
		if (a < V_LO) r = V_LO;
		return COORD_WIDTH'(r);
	endfunction

	logic   out_v_q;
	logic   last_q;
	coord_t px_q, py_q;

	assign adv = !out_v_q || pts.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= tag.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_q   <= sat(vx);
			py_q   <= sat(vy);
			last_q <= tag.last;
		end
	end

	assign pts.valid = out_v_q;
	assign pts.px    = px_q;
	assign pts.py    = py_q;
	assign pts.last  = last_q;

endmodule

// ===== sv/csst_checker.sv =====
// Port-level checker for the tessellator and its bind.
module csst_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             seg_valid,
	input logic             seg_ready,
	input logic [csst_pkg::OP_W-1:0] seg_op,
	input logic             pts_valid,
	input logic             pts_ready,
	input csst_pkg::coord_t px,
	input csst_pkg::coord_t py,
	input logic             last
);
	import csst_pkg::*;

	logic        seg_take, pt_take;
	step_t       pcnt_q;
	logic [2:0]  pend_q;

	assign seg_take = seg_valid && seg_ready && (seg_op != OP_NONE);
	assign pt_take  = pts_valid && pts_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= '0;
			pend_q <= '0;
		end else begin
			if (pt_take) begin
				pcnt_q <= last ? '0 : pcnt_q + STEP_W'(1);
			end
			pend_q <= pend_q + 3'(seg_take) - 3'(pt_take && last);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pts_valid && !pts_ready |=> pts_valid && $stable(px) && $stable(py) && $stable(last))
		else $error("point word changed while stalled");

	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		pt_take && !last |-> pcnt_q < STEP_W'(SEGMENT_STEPS))
		else $error("too many points without last");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		pt_take && last |-> pcnt_q == STEP_W'(SEGMENT_STEPS))
		else $error("last flag on wrong point");

	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pts_valid |-> pend_q != 3'd0)
		else $error("point with no segment outstanding");

	a_rst: assert property (@(posedge clk) !arst_n |-> !pts_valid)
		else $error("point valid during reset");

endmodule

bind cubic_spline_segment_tessellator csst_checker u_csst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.seg_valid (seg.valid),
	.seg_ready (seg.ready),
	.seg_op    (seg.op),
	.pts_valid (pts.valid),
	.pts_ready (pts.ready),
	.px        (pts.px),
	.py        (pts.py),
	.last      (pts.last)
);

// ===== verif/tb_cubic_spline_segment_tessellator.sv =====
// Self-checking testbench for the cubic segment tessellator: directed table, random phases.
module tb_cubic_spline_segment_tessellator;
	import csst_pkg::*;

	// Segment word as the sender sees it, and one row of the directed table.
	typedef struct packed {
		logic [OP_W-1:0] op;
		coord_t          c0_x;
		coord_t          c0_y;
		coord_t          c1_x;
		coord_t          c1_y;
		coord_t          c2_x;
		coord_t          c2_y;
		coord_t          c3_x;
		coord_t          c3_y;
	} seg_word_t;

	// fixed: the points at t=0 and t=1 are typed in below (p0_*, p1_*)
	// and take the place of the predicted ones for those two words.
	typedef struct packed {
		seg_word_t w;
		logic      fixed;
		coord_t    p0_x;
		coord_t    p0_y;
		coord_t    p1_x;
		coord_t    p1_y;
	} dir_row_t;

	typedef struct packed {
		coord_t px;
		coord_t py;
		logic   last;
	} point_t;

	localparam int     CLK_HALF     = 10;
	localparam int     RESET_CYCLES = 6;
	localparam int     DRAIN_CYCLES = 40;    // well past the time a point takes through the block
	localparam int     HOLD_CYCLES  = 400;   // long receiver hold-off
	localparam int     RAND_SEGS    = 340;   // random segments that make points
	localparam int     PHASE_SEGS   = RAND_SEGS / 5;
	localparam int     LIMIT_CYCLES = 400000;
	localparam longint COORD_MAX    = (longint'(1) << (COORD_WIDTH - 1)) - 1;
	localparam longint COORD_MIN    = -COORD_MAX - 1;
	localparam longint SIXTH_Q16    = SIXTH;

	// Handy Q3.12 values for the table
	localparam coord_t ZR  = 16'sh0000;
	localparam coord_t MX  = 16'sh7FFF;
	localparam coord_t MN  = 16'sh8000;
	localparam coord_t ONE = 16'sh1000;
	localparam coord_t NEG = 16'shF000;
	localparam coord_t KAP = 16'sh08D6;   // ~0.552, quarter-circle handle
	localparam coord_t AA  = 16'shAAAA;
	localparam coord_t P55 = 16'sh5555;
	localparam coord_t LSB = 16'sh0001;
	localparam coord_t M1  = 16'shFFFF;

	localparam int DIR_N = 21;

	// Hermite: P(0) = c0 and P(1) = c1 exactly. Bezier: P(0) = c0, P(1) = c3.
	// B-spline endpoints go through the rounded sixths, so those rows lean on
	// the predictor. Ignored selector rows must give no points at all.
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{'{OP_HERMITE, ZR, ZR, ZR, ZR, ZR, ZR, ZR, ZR}, 1'b1, ZR, ZR, ZR, ZR},
		'{'{OP_HERMITE, MX, MN, MN, MX, ZR, ZR, ZR, ZR}, 1'b1, MX, MN, MN, MX},
		'{'{OP_HERMITE, ONE, NEG, NEG, ONE, MX, MN, MX, MN}, 1'b1, ONE, NEG, NEG, ONE},
		'{'{OP_HERMITE, ZR, ZR, ZR, ZR, MN, MX, MN, MX}, 1'b1, ZR, ZR, ZR, ZR},
		'{'{OP_BEZIER, MX, MX, MX, MX, MX, MX, MX, MX}, 1'b1, MX, MX, MX, MX},
		'{'{OP_BEZIER, MN, MN, MN, MN, MN, MN, MN, MN}, 1'b1, MN, MN, MN, MN},
		'{'{OP_BEZIER, MN, MX, MX, MN, MN, MX, MX, MN}, 1'b1, MN, MX, MX, MN},
		'{'{OP_BEZIER, AA, P55, P55, AA, AA, P55, P55, AA}, 1'b1, AA, P55, P55, AA},
		'{'{OP_BEZIER, ONE, ZR, ONE, KAP, KAP, ONE, ZR, ONE}, 1'b1, ONE, ZR, ZR, ONE},
		'{'{OP_BEZIER, LSB, M1, M1, LSB, LSB, M1, M1, LSB}, 1'b1, LSB, M1, M1, LSB},
		'{'{OP_BSPLINE, ZR, ZR, ZR, ZR, ZR, ZR, ZR, ZR}, 1'b1, ZR, ZR, ZR, ZR},
		'{'{OP_BSPLINE, MX, MX, MX, MX, MX, MX, MX, MX}, 1'b0, ZR, ZR, ZR, ZR},
		'{'{OP_BSPLINE, MN, MN, MN, MN, MN, MN, MN, MN}, 1'b0, ZR, ZR, ZR, ZR},
		'{'{OP_BSPLINE, MX, MN, MN, MX, MX, MN, MN, MX}, 1'b0, ZR, ZR, ZR, ZR},
		'{'{OP_BSPLINE, ZR, ZR, ONE, NEG, ONE, ONE, ZR, ONE}, 1'b0, ZR, ZR, ZR, ZR},
		'{'{OP_BSPLINE, LSB, M1, M1, LSB, LSB, M1, M1, LSB}, 1'b0, ZR, ZR, ZR, ZR},
		'{'{OP_NONE, MX, MX, MX, MX, MX, MX, MX, MX}, 1'b0, ZR, ZR, ZR, ZR},
		'{'{OP_NONE, ZR, ZR, ZR, ZR, ZR, ZR, ZR, ZR}, 1'b0, ZR, ZR, ZR, ZR},
		'{'{OP_HERMITE, AA, P55, P55, AA, ONE, NEG, NEG, ONE}, 1'b1, AA, P55, P55, AA},
		'{'{OP_BSPLINE, AA, P55, P55, AA, MX, MN, M1, LSB}, 1'b0, ZR, ZR, ZR, ZR},
		'{'{OP_HERMITE, MX, MX, MX, MX, MX, MX, MN, MN}, 1'b1, MX, MX, MX, MX}
	};

	logic clk;
	logic arst_n;

	csst_seg_if seg_bus ();
	csst_pt_if  pt_bus ();

	cubic_spline_segment_tessellator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.seg    (seg_bus),
		.pts    (pt_bus)
	);

	// Points still owed by the block, oldest first
	point_t      expected_points [$];
	int unsigned mismatch_cnt = 0;

	// Idle knobs, changed by the main flow between phases
	int unsigned src_idle_pct  = 0;
	int unsigned sink_stall_pct = 0;
	bit          hold_req      = 1'b0;

	// Half-up rounding at 16 fraction bits: floor(x / 65536 + 0.5)
	function automatic longint round_q16(input longint x);
		return (x + 32768) >>> 16;
	endfunction

	// One axis of the curve at step idx: basis matrix, then Horner in Q1.16 t,
	// saturated only at the end.
	function automatic coord_t curve_coord(input logic [OP_W-1:0] op,
		input coord_t q0, input coord_t q1, input coord_t q2, input coord_t q3,
		input int unsigned idx);
		longint p0, p1, p2, p3;
		longint a0, a1, a2, a3;
		longint tq, v;
		p0 = q0;
		p1 = q1;
		p2 = q2;
		p3 = q3;
		case (op)
		OP_HERMITE: begin
			a0 = p0;
			a1 = p2;
			a2 = -3 * p0 + 3 * p1 - 2 * p2 - p3;
			a3 = 2 * p0 - 2 * p1 + p2 + p3;
		end
		OP_BEZIER: begin
			a0 = p0;
			a1 = -3 * p0 + 3 * p1;
			a2 = 3 * p0 - 6 * p1 + 3 * p2;
			a3 = -p0 + 3 * p1 - 3 * p2 + p3;
		end
		default: begin
			a0 = round_q16((p0 + 4 * p1 + p2) * SIXTH_Q16);
			a1 = round_q16((-3 * p0 + 3 * p2) * SIXTH_Q16);
			a2 = round_q16((3 * p0 - 6 * p1 + 3 * p2) * SIXTH_Q16);
			a3 = round_q16((-p0 + 3 * p1 - 3 * p2 + p3) * SIXTH_Q16);
		end
		endcase
		tq = ((longint'(idx) << FRAC_W) + SEGMENT_STEPS / 2) / SEGMENT_STEPS;
		v = a3;
		v = a2 + round_q16(v * tq);
		v = a1 + round_q16(v * tq);
		v = a0 + round_q16(v * tq);
		if (v > COORD_MAX)
			v = COORD_MAX;
		else if (v < COORD_MIN)
			v = COORD_MIN;
		return coord_t'(v);
	endfunction

	// Queue every point of an accepted segment word. A typed-in row replaces
	// the end points with its own values.
	function automatic void queue_points(input dir_row_t r);
		point_t pt;
		if (r.w.op == OP_NONE)
			return;
		for (int unsigned i = 0; i <= SEGMENT_STEPS; i++) begin
			pt.px   = curve_coord(r.w.op, r.w.c0_x, r.w.c1_x, r.w.c2_x, r.w.c3_x, i);
			pt.py   = curve_coord(r.w.op, r.w.c0_y, r.w.c1_y, r.w.c2_y, r.w.c3_y, i);
			pt.last = (i == SEGMENT_STEPS);
			if (r.fixed && i == 0) begin
				pt.px = r.p0_x;
				pt.py = r.p0_y;
			end else if (r.fixed && i == SEGMENT_STEPS) begin
				pt.px = r.p1_x;
				pt.py = r.p1_y;
			end
			expected_points.push_back(pt);
		end
	endfunction

	// Mostly full-range values, with a good share of extremes, zero and small ones
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
		0: return MX;
		1: return MN;
		2: return ZR;
		3: return coord_t'(int'($urandom_range(0, 8191)) - 4096);
		default: return coord_t'($urandom);
		endcase
	endfunction

	// Offer one segment word after an optional idle gap; returns at the accepting edge.
	task automatic send_segment(input seg_word_t w);
		int unsigned gap;
		gap = 0;
		while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
			gap++;
		if (gap > 0) begin
			seg_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		seg_bus.valid <= 1'b1;
		seg_bus.op    <= w.op;
		seg_bus.c0_x  <= w.c0_x;
		seg_bus.c0_y  <= w.c0_y;
		seg_bus.c1_x  <= w.c1_x;
		seg_bus.c1_y  <= w.c1_y;
		seg_bus.c2_x  <= w.c2_x;
		seg_bus.c2_y  <= w.c2_y;
		seg_bus.c3_x  <= w.c3_x;
		seg_bus.c3_y  <= w.c3_y;
		do
			@(posedge clk);
		while (seg_bus.ready !== 1'b1);
	endtask

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#(2 * CLK_HALF * LIMIT_CYCLES);
		$display("TEST FAILED");
		$finish;
	end

	// Point receiver: random stalls per phase, plus one long hold-off on request
	initial begin : point_sink
		pt_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				pt_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				pt_bus.ready <= (sink_stall_pct == 0) ||
					($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	// Compare every taken point word against the oldest expectation
	always @(posedge clk) begin : point_check
		point_t want;
		if (pt_bus.valid === 1'b1 && pt_bus.ready === 1'b1) begin
			if (expected_points.size() == 0) begin
				$error("unexpected point word: px=%0d py=%0d last=%0b",
					pt_bus.px, pt_bus.py, pt_bus.last);
				mismatch_cnt++;
			end else begin
				want = expected_points.pop_front();
				if (pt_bus.px !== want.px) begin
					$error("px: expected %0d, got %0d", want.px, pt_bus.px);
					mismatch_cnt++;
				end
				if (pt_bus.py !== want.py) begin
					$error("py: expected %0d, got %0d", want.py, pt_bus.py);
					mismatch_cnt++;
				end
				if (pt_bus.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, pt_bus.last);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin : main_flow
		dir_row_t    r;
		int unsigned made;
		int unsigned phase;
		arst_n        <= 1'b0;
		seg_bus.valid <= 1'b0;
		seg_bus.op    <= OP_HERMITE;
		seg_bus.c0_x  <= '0;
		seg_bus.c0_y  <= '0;
		seg_bus.c1_x  <= '0;
		seg_bus.c1_y  <= '0;
		seg_bus.c2_x  <= '0;
		seg_bus.c2_y  <= '0;
		seg_bus.c3_x  <= '0;
		seg_bus.c3_y  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: extremes, every basis, the ignored selector, saturation
		for (int k = 0; k < DIR_N; k++) begin
			send_segment(DIR_ROWS[k].w);
			queue_points(DIR_ROWS[k]);
		end

		// Random segments in phases: free-running, sender gaps, receiver stalls,
		// both, then a long receiver hold-off with the sender pushing hard so
		// the block backs up and drops seg.ready.
		made  = 0;
		phase = 0;
		r     = '0;
		while (made < RAND_SEGS) begin
			if (made == phase * PHASE_SEGS) begin
				case (phase)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
				3: begin src_idle_pct = 23; sink_stall_pct = 23; end
				default: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
					hold_req       = 1'b1;
				end
				endcase
				phase++;
			end
			// a few ignored selectors sprinkled in; they do not count
			r.w.op   = ($urandom_range(0, 99) < 6) ? OP_NONE :
				OP_W'($urandom_range(0, 2));
			r.w.c0_x = rand_coord();
			r.w.c0_y = rand_coord();
			r.w.c1_x = rand_coord();
			r.w.c1_y = rand_coord();
			r.w.c2_x = rand_coord();
			r.w.c2_y = rand_coord();
			r.w.c3_x = rand_coord();
			r.w.c3_y = rand_coord();
			send_segment(r.w);
			queue_points(r);
			if (r.w.op != OP_NONE)
				made++;
		end
		seg_bus.valid <= 1'b0;

		// Drain, then a quiet stretch to catch any stray point words
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
